[rtl/core/imu_serial_frame_parser_top_defines.svh]
// Assertion macros used by the IMU frame parser checker.
`ifndef IMU_SERIAL_FRAME_PARSER_TOP_DEFINES_SVH
`define IMU_SERIAL_FRAME_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define IMU_SFP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define IMU_SFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/imu_sfp_pkg.sv]
// Package: constants and widths of the IMU serial frame parser.
`timescale 1ns / 1ps
package imu_sfp_pkg;

	localparam int BYTE_W     = 8;
	localparam int RAW_W      = 16;
	localparam int FS_W       = 12;
	localparam int AXIS_W     = 21;
	localparam int POS_W      = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int PAY_BYTES  = 6;                  // bytes used of the eight-byte payload
	localparam int PAY_IDX_W  = $clog2(PAY_BYTES);
	localparam int FRAC_BITS  = 8;
	localparam int RAW_SHIFT  = 15;
	localparam int PROD_W     = RAW_W + FS_W + 1;
	localparam int TDATA_IN_W = 8;
	localparam int TDATA_OUT_W = ((3 * AXIS_W + 7) / 8) * 8;

	localparam logic [BYTE_W-1:0] HDR_BYTE   = 8'h55;
	localparam logic [BYTE_W-1:0] TYPE_ANGLE = 8'h53;
	localparam logic [BYTE_W-1:0] TYPE_RATE  = 8'h52;

	localparam logic [POS_W-1:0] POS_HUNT  = 4'd0;
	localparam logic [POS_W-1:0] POS_TYPE  = 4'd1;
	localparam logic [POS_W-1:0] POS_PAY0  = 4'd2;
	localparam logic [POS_W-1:0] POS_CSUM  = 4'd10;

	localparam logic KIND_ANGLE = 1'b0;
	localparam logic KIND_RATE  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_FS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_FS  = 1'd1;

	localparam logic [FS_W-1:0] ANGLE_FS_RST = 12'd180;
	localparam logic [FS_W-1:0] RATE_FS_RST  = 12'd2000;

	localparam logic signed [PROD_W-1:0] AXIS_MAX =
		PROD_W'((longint'(1) << (AXIS_W - 1)) - 1);
	localparam logic signed [PROD_W-1:0] AXIS_MIN =
		PROD_W'(-(longint'(1) << (AXIS_W - 1)));

endpackage

[rtl/core/imu_sfp_scale.sv]
// One axis lane: raw * full_scale, floored shift to fixed point, saturate.
`timescale 1ns / 1ps
module imu_sfp_scale
	import imu_sfp_pkg::*;
(
	input  logic signed [RAW_W-1:0]  raw,
	input  logic        [FS_W-1:0]   full_scale,
	output logic signed [AXIS_W-1:0] axis
);

	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] shifted;

	// arithmetic right shift floors toward minus infinity
	assign prod    = PROD_W'(raw) * $signed({1'b0, full_scale});
	assign shifted = prod >>> (RAW_SHIFT - FRAC_BITS);

	always_comb begin
		if (shifted > AXIS_MAX) begin
			axis = AXIS_MAX[AXIS_W-1:0];
		end else if (shifted < AXIS_MIN) begin
			axis = AXIS_MIN[AXIS_W-1:0];
		end else begin
			axis = shifted[AXIS_W-1:0];
		end
	end

endmodule

[rtl/core/imu_serial_frame_parser_top.sv]
// Top level: IMU UART frame hunter, checksum check and axis scaling.
`timescale 1ns / 1ps
// Throughput: one byte beat per cycle; s_tready drops only while both the
//   scaling stage and the output register hold results and the output stalls.
// Path: a good frame is registered in the s1 frame register on its checksum
//   byte beat, then passes through the multipliers into the s2 output register.
// Reset: arst_n clears the frame position, checksum, valid flags and loads
//   full scales 180 and 2000; payload registers are not reset.
module imu_serial_frame_parser_top
	import imu_sfp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// input byte stream
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [TDATA_IN_W-1:0]   s_tdata,   // [7:0] rx_byte
	// result stream
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [TDATA_OUT_W-1:0]  m_tdata,   // [20:0] axis_x, [41:21] axis_y,
	                                           // [62:42] axis_z, [63] zero
	output logic                    m_tuser,   // [0] frame_kind
	// configuration writes
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [FS_W-1:0]         cfg_data
);

	// config registers
	logic [FS_W-1:0] angle_fs_q;
	logic [FS_W-1:0] rate_fs_q;

	// frame hunter state
	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] type_q;
	logic [BYTE_W-1:0] sum_q;
	logic [BYTE_W-1:0] pay_q [PAY_BYTES];

	// s1: completed good frame
	logic                   valid_s1;
	logic                   kind_s1;
	logic [FS_W-1:0]        fs_s1;
	logic signed [RAW_W-1:0] raw_s1 [3];

	// s2: output register
	logic                    valid_s2;
	logic                    kind_s2;
	logic signed [AXIS_W-1:0] axis_s2 [3];

	logic                    s_beat;
	logic                    out_free;
	logic [BYTE_W-1:0]       rx_byte;
	logic                    type_ok;
	logic                    frame_good;
	logic [PAY_IDX_W-1:0]    pay_idx;
	logic [POS_W-1:0]        pay_off;
	logic signed [AXIS_W-1:0] axis_new [3];

	assign rx_byte  = s_tdata[BYTE_W-1:0];
	assign out_free = !valid_s2 || m_tready;
	// s1 only fills on a checksum byte; hold input while it cannot drain
	assign s_tready = !valid_s1 || out_free;
	assign s_beat   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign pay_off = pos_q - POS_PAY0;
	assign pay_idx = pay_off[PAY_IDX_W-1:0];

	assign type_ok    = (type_q == TYPE_ANGLE) || (type_q == TYPE_RATE);
	// positions beyond the checksum slot are treated as the checksum slot
	assign frame_good = s_beat && (pos_q >= POS_CSUM) && (rx_byte == sum_q) && type_ok;

	// config writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_fs_q <= ANGLE_FS_RST;
			rate_fs_q  <= RATE_FS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ANGLE_FS: angle_fs_q <= cfg_data;
				CFG_RATE_FS:  rate_fs_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// frame position, type byte and running checksum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_HUNT;
			type_q <= '0;
			sum_q  <= '0;
		end else if (s_beat) begin
			if (pos_q == POS_HUNT) begin
				if (rx_byte == HDR_BYTE) begin
					pos_q  <= POS_TYPE;
					sum_q  <= HDR_BYTE;
					type_q <= '0;
				end
			end else if (pos_q == POS_TYPE) begin
				type_q <= rx_byte;
				sum_q  <= sum_q + rx_byte;
				pos_q  <= POS_PAY0;
			end else if (pos_q < POS_CSUM) begin
				sum_q <= sum_q + rx_byte;
				pos_q <= pos_q + 1'b1;
			end else begin
				// checksum byte: back to hunting whatever the outcome
				pos_q <= POS_HUNT;
			end
		end
	end

	// payload bytes 0..5; bytes 6 and 7 are counted but not kept
	always_ff @(posedge clk) begin
		if (s_beat && (pos_q >= POS_PAY0) && (pos_q < POS_CSUM)
				&& (pay_off < POS_W'(PAY_BYTES))) begin
			pay_q[pay_idx] <= rx_byte;
		end
	end

	// s1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_good) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	// s1 payload: little-endian words, full scale picked by frame type
	always_ff @(posedge clk) begin
		if (frame_good) begin
			kind_s1   <= (type_q == TYPE_RATE) ? KIND_RATE : KIND_ANGLE;
			fs_s1     <= (type_q == TYPE_RATE) ? rate_fs_q : angle_fs_q;
			raw_s1[0] <= {pay_q[1], pay_q[0]};
			raw_s1[1] <= {pay_q[3], pay_q[2]};
			raw_s1[2] <= {pay_q[5], pay_q[4]};
		end
	end

	// three scaling lanes between s1 and s2
	for (genvar g = 0; g < 3; g++) begin : g_lane
		imu_sfp_scale u_scale (
			.raw        (raw_s1[g]),
			.full_scale (fs_s1),
			.axis       (axis_new[g])
		);
	end

	// s2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	// s2 payload
	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			kind_s2    <= kind_s1;
			axis_s2[0] <= axis_new[0];
			axis_s2[1] <= axis_new[1];
			axis_s2[2] <= axis_new[2];
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = kind_s2;
	assign m_tdata  = {{(TDATA_OUT_W - 3 * AXIS_W){1'b0}}, axis_s2[2], axis_s2[1], axis_s2[0]};

endmodule

[rtl/core/imu_sfp_checker.sv]
// Port-level checker for the IMU frame parser, bound to the top level.
`timescale 1ns / 1ps
`include "imu_serial_frame_parser_top_defines.svh"
module imu_sfp_checker
	import imu_sfp_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [TDATA_OUT_W-1:0] m_tdata
);

	// a result beat stays offered until taken
	`IMU_SFP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")

	// input back-pressure only comes from a stalled full output
	`IMU_SFP_ASSERT_NOW(a_in_stall, !s_tready, m_tvalid && !m_tready, "input stalled with output free")

	// pad bit above the three axes is always zero
	`IMU_SFP_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[TDATA_OUT_W-1] == 1'b0, "tdata pad bit set")

endmodule

bind imu_serial_frame_parser_top imu_sfp_checker u_imu_sfp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[bench/tb_imu_serial_frame_parser_top.sv]
// Testbench: IMU frame parser byte stream, with an axis scoreboard and random stalls.
`timescale 1ns / 1ps
module tb_imu_serial_frame_parser_top;
	import imu_sfp_pkg::*;

	// One result beat as the block should present it.
	typedef struct packed {
		logic                     kind;
		logic signed [AXIS_W-1:0] x;
		logic signed [AXIS_W-1:0] y;
		logic signed [AXIS_W-1:0] z;
	} axis_result_t;

	// Tracks the frame hunter byte by byte and keeps the axis results
	// that valid angle and rate frames must produce, oldest first.
	class axis_scoreboard;
		logic [FS_W-1:0]   angle_fs;
		logic [FS_W-1:0]   rate_fs;
		logic [POS_W-1:0]  pos;
		logic [BYTE_W-1:0] ftype;
		logic [BYTE_W-1:0] sum;
		logic [63:0]       pay;
		axis_result_t      expected_axes[$];
		int                mismatches;

		function new();
			angle_fs = ANGLE_FS_RST;
			rate_fs = RATE_FS_RST;
			pos = POS_HUNT;
			ftype = '0;
			sum = '0;
			pay = '0;
			mismatches = 0;
		endfunction

		function void set_scale(logic [CFG_IDX_W-1:0] idx, logic [FS_W-1:0] val);
			if (idx == CFG_ANGLE_FS) begin
				angle_fs = val;
			end else begin
				rate_fs = val;
			end
		endfunction

		// raw * fs * 2^FRAC_BITS / 2^15, floored, clamped to the axis width
		function logic signed [AXIS_W-1:0] scaled_axis(logic [RAW_W-1:0] raw,
				logic [FS_W-1:0] fs);
			longint p;
			longint hi;
			hi = (longint'(1) << (AXIS_W - 1)) - 1;
			p = longint'($signed(raw)) * longint'(fs);
			p = (p <<< FRAC_BITS) >>> RAW_SHIFT;
			if (p > hi) p = hi;
			if (p < -hi - 1) p = -hi - 1;
			return p[AXIS_W-1:0];
		endfunction

		function void absorb_byte(logic [BYTE_W-1:0] b);
			int idx;
			logic [FS_W-1:0] fs;
			axis_result_t r;
			if (pos == POS_HUNT) begin
				if (b == HDR_BYTE) begin
					pos = POS_TYPE;
					sum = HDR_BYTE;
					ftype = '0;
					pay = '0;
				end
			end else if (pos == POS_TYPE) begin
				ftype = b;
				sum += b;
				pos = POS_PAY0;
			end else if (pos < POS_CSUM) begin
				idx = int'(pos) - int'(POS_PAY0);
				pay[idx*8 +: 8] = b;
				sum += b;
				pos = pos + 1'b1;
			end else begin
				// checksum byte; back to hunting whatever the outcome
				pos = POS_HUNT;
				if (b == sum && (ftype == TYPE_ANGLE || ftype == TYPE_RATE)) begin
					r.kind = (ftype == TYPE_RATE) ? KIND_RATE : KIND_ANGLE;
					fs = (ftype == TYPE_RATE) ? rate_fs : angle_fs;
					r.x = scaled_axis(pay[15:0], fs);
					r.y = scaled_axis(pay[31:16], fs);
					r.z = scaled_axis(pay[47:32], fs);
					expected_axes.push_back(r);
				end
			end
		endfunction

		function void note_mismatch(string msg);
			mismatches++;
			if (mismatches <= 10) $display("%s", msg);
		endfunction

		function void compare_axes(axis_result_t got);
			axis_result_t want;
			if (expected_axes.size() == 0) begin
				note_mismatch($sformatf("unexpected result kind %0d x %0d y %0d z %0d",
					got.kind, got.x, got.y, got.z));
				return;
			end
			want = expected_axes.pop_front();
			if (got.kind !== want.kind || got.x !== want.x || got.y !== want.y ||
					got.z !== want.z) begin
				note_mismatch($sformatf(
					"result mismatch: exp kind %0d x %0d y %0d z %0d, got kind %0d x %0d y %0d z %0d",
					want.kind, want.x, want.y, want.z, got.kind, got.x, got.y, got.z));
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [TDATA_IN_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [FS_W-1:0]        cfg_data = '0;

	axis_scoreboard sb = new();

	int bytes_sent = 0;
	int hold_off_cycles = 0;   // long receiver hold-off, counted down by the sink
	bit tx_burst = 1'b0;       // sender runs back to back while set

	imu_serial_frame_parser_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Mostly no gap, some short ones, a few long ones.
	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Axis word with a bias toward the extremes and toward header bytes.
	function logic [RAW_W-1:0] pick_word();
		case ($urandom_range(0, 11))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'hFFFF;
			3: return 16'h0001;
			4: return {HDR_BYTE, 8'($urandom)};
			default: return 16'($urandom);
		endcase
	endfunction

	// One byte beat; valid stays high into the next beat unless a gap follows.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		sb.absorb_byte(b);
		bytes_sent++;
		gap = tx_burst ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Header, type, eight payload bytes, checksum (optionally spoiled).
	task automatic send_frame(input logic [BYTE_W-1:0] ftype, input logic [63:0] pay,
			input bit spoil);
		logic [BYTE_W-1:0] sum;
		sum = HDR_BYTE + ftype;
		for (int i = 0; i < 8; i++) sum += pay[i*8 +: 8];
		if (spoil) sum += 8'($urandom_range(1, 255));
		send_byte(HDR_BYTE);
		send_byte(ftype);
		for (int i = 0; i < 8; i++) send_byte(pay[i*8 +: 8]);
		send_byte(sum);
	endtask

	// Both full scales back to back; valid only drops after the second beat.
	task automatic write_scales(input logic [FS_W-1:0] angle_fs,
			input logic [FS_W-1:0] rate_fs);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_ANGLE_FS;
		cfg_data <= angle_fs;
		do @(posedge clk); while (!cfg_ready);
		sb.set_scale(CFG_ANGLE_FS, angle_fs);
		cfg_index <= CFG_RATE_FS;
		cfg_data <= rate_fs;
		do @(posedge clk); while (!cfg_ready);
		sb.set_scale(CFG_RATE_FS, rate_fs);
		cfg_valid <= 1'b0;
	endtask

	// Stop sending, let every expected result out, then cover the pipeline
	// (two stages) for frames that end without a result.
	task automatic wait_drained(input int tail);
		s_tvalid <= 1'b0;
		while (sb.expected_axes.size() != 0) @(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	// Mostly well-formed frames with random content; the rest is truncated
	// frames, foreign types, bad checksums and line noise.
	task automatic random_phase(input int target);
		int start;
		int r;
		int n;
		logic [BYTE_W-1:0] ftype;
		logic [63:0] pay;
		start = bytes_sent;
		while (bytes_sent - start < target) begin
			r = $urandom_range(0, 99);
			if (r < 72) begin
				n = $urandom_range(0, 9);
				ftype = (n < 4) ? TYPE_ANGLE : (n < 8) ? TYPE_RATE : 8'($urandom);
				pay = {8'($urandom), 8'($urandom), pick_word(), pick_word(), pick_word()};
				send_frame(ftype, pay, $urandom_range(0, 7) == 0);
			end else if (r < 82) begin
				// frame cut short; the bytes after it fill the remaining slots
				send_byte(HDR_BYTE);
				n = $urandom_range(1, 9);
				repeat (n) send_byte(8'($urandom));
			end else begin
				n = $urandom_range(1, 4);
				repeat (n) send_byte(8'($urandom));
			end
		end
	endtask

	// Sink: checks every result beat and drives tready with random stalls,
	// plus the long hold-off that backs the block up into its input.
	initial begin
		axis_result_t got;
		int rx_gap;
		bit rx_burst;
		int tick;
		rx_gap = 0;
		rx_burst = 1'b0;
		tick = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.kind = m_tuser;
				got.x = m_tdata[AXIS_W-1:0];
				got.y = m_tdata[2*AXIS_W-1:AXIS_W];
				got.z = m_tdata[3*AXIS_W-1:2*AXIS_W];
				sb.compare_axes(got);
			end
			tick++;
			if (tick % 64 == 0) rx_burst = ($urandom_range(0, 2) == 0);
			if (hold_off_cycles > 0) begin
				hold_off_cycles--;
				m_tready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				rx_gap = rx_burst ? 0 : pick_gap();
			end
		end
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#5000000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		logic [FS_W-1:0] angle_set[6];
		logic [FS_W-1:0] rate_set[6];
		// phase 0 runs on reset values; phases 1 to 3 hit both ends and zero, 4 and 5 are random
		angle_set = '{ANGLE_FS_RST, 12'd4095, 12'd1, 12'd0, 12'd0, 12'd0};
		rate_set = '{RATE_FS_RST, 12'd1, 12'd4095, 12'd0, 12'd0, 12'd0};
		for (int i = 4; i < 6; i++) begin
			angle_set[i] = 12'($urandom_range(1, 4095));
			rate_set[i] = 12'($urandom_range(1, 4095));
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: noise while hunting, then an angle and a rate frame with
		// extreme axis words and a header byte inside the payload.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame(TYPE_ANGLE, {8'h00, HDR_BYTE, 16'hFFFF, 16'h8000, 16'h7FFF}, 1'b0);
		send_frame(TYPE_RATE, {16'hFFFF, 16'h8000, 16'h0000, 16'h0001}, 1'b0);

		for (int ph = 0; ph < 6; ph++) begin
			if (ph > 0) begin
				wait_drained(8);
				write_scales(angle_set[ph], rate_set[ph]);
			end
			tx_burst = ($urandom_range(0, 3) == 0);
			if (ph == 1) begin
				// receiver goes quiet while frames keep coming back to back
				tx_burst = 1'b1;
				hold_off_cycles = 400;
			end
			random_phase(112);
		end

		wait_drained(20);
		if (sb.mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
